[hdl/wmg_pkg.sv]
// ============================================================================
// Windowed watchdog motor guard package
// Shared types, codes, constants and helper functions of the guard block.
// ============================================================================
package wmg_pkg;

    // Width of the wrapping window counter.
    localparam int WINDOW_COUNTER_BITS = 16;
    // Width used to compare the counter against the 16-bit window limits.
    localparam int CMP_BITS = (WINDOW_COUNTER_BITS > 16) ? WINDOW_COUNTER_BITS : 16;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [7:0] BRAKE_DUTY = 8'hFF;

    // Register reset values.
    localparam logic [15:0] WINDOW_LOW_RST      = 16'd34800;
    localparam logic [15:0] WINDOW_HIGH_RST     = 16'd37800;
    localparam logic [6:0]  FAULT_LIMIT_RST     = 7'd10;
    localparam logic [11:0] ACTIVITY_PERIOD_RST = 12'd3600;
    localparam logic [7:0]  NORMAL_DUTY_RST     = 8'h35;
    localparam logic [7:0]  TURBO_DUTY_RST      = 8'h70;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_WINDOW_LOW        = 3'd0,
        REG_WINDOW_HIGH       = 3'd1,
        REG_FAULT_LIMIT       = 3'd2,
        REG_ACTIVITY_PERIOD   = 3'd3,
        REG_LEFT_NORMAL_DUTY  = 3'd4,
        REG_LEFT_TURBO_DUTY   = 3'd5,
        REG_RIGHT_NORMAL_DUTY = 3'd6,
        REG_RIGHT_TURBO_DUTY  = 3'd7
    } reg_index_t;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_KICK      = 3'd1,
        OP_START     = 3'd2,
        OP_RESET     = 3'd3,
        OP_LOW_BATT  = 3'd4,
        OP_MOTOR_CMD = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        CMD_STOP           = 3'd0,
        CMD_FORWARD        = 3'd1,
        CMD_BACKWARD       = 3'd2,
        CMD_FORWARD_TURBO  = 3'd3,
        CMD_BACKWARD_TURBO = 3'd4
    } motor_cmd_t;

    // Output encoding of the system state.
    localparam logic [1:0] CODE_WAITING  = 2'd0;
    localparam logic [1:0] CODE_ACTIVE   = 2'd1;
    localparam logic [1:0] CODE_INACTIVE = 2'd2;
    localparam logic [1:0] CODE_LOW_BATT = 2'd3;

    // System state machine, one-hot.
    typedef enum logic [3:0] {
        ST_WAITING  = 4'b0001,
        ST_ACTIVE   = 4'b0010,
        ST_INACTIVE = 4'b0100,
        ST_LOW_BATT = 4'b1000
    } sys_state_t;

    typedef struct packed {
        logic [15:0] window_low;
        logic [15:0] window_high;
        logic [6:0]  fault_limit;
        logic [11:0] activity_period;
        logic [7:0]  left_normal_duty;
        logic [7:0]  left_turbo_duty;
        logic [7:0]  right_normal_duty;
        logic [7:0]  right_turbo_duty;
    } cfg_t;

    typedef struct packed {
        logic [2:0] operation;
        logic       with_watchdog;
        logic       motor_select;
        logic [2:0] motor_command;
    } item_t;

    typedef struct packed {
        logic [1:0] system_state;
        logic       command_ok;
        logic       activity_pulse;
        logic       emitter_enable;
        logic [7:0] left_duty_a;
        logic [7:0] left_duty_b;
        logic [7:0] right_duty_a;
        logic [7:0] right_duty_b;
    } result_t;

    function automatic logic [1:0] state_code(input sys_state_t st);
        logic [1:0] code;
        case (st)
            ST_WAITING:  code = CODE_WAITING;
            ST_ACTIVE:   code = CODE_ACTIVE;
            ST_INACTIVE: code = CODE_INACTIVE;
            ST_LOW_BATT: code = CODE_LOW_BATT;
            default:     code = CODE_WAITING;
        endcase
        return code;
    endfunction

endpackage

[hdl/wmg_chan_if.sv]
// ============================================================================
// Windowed watchdog motor guard channels
// Valid/ready channels for input items, results and register writes.
// ============================================================================
interface wmg_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic       with_watchdog;
    logic       motor_select;
    logic [2:0] motor_command;

    modport source (output valid, operation, with_watchdog, motor_select, motor_command,
                    input ready);
    modport sink   (input valid, operation, with_watchdog, motor_select, motor_command,
                    output ready);
endinterface

interface wmg_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] system_state;
    logic       command_ok;
    logic       activity_pulse;
    logic       emitter_enable;
    logic [7:0] left_duty_a;
    logic [7:0] left_duty_b;
    logic [7:0] right_duty_a;
    logic [7:0] right_duty_b;

    modport source (output valid, system_state, command_ok, activity_pulse, emitter_enable,
                    left_duty_a, left_duty_b, right_duty_a, right_duty_b,
                    input ready);
    modport sink   (input valid, system_state, command_ok, activity_pulse, emitter_enable,
                    left_duty_a, left_duty_b, right_duty_a, right_duty_b,
                    output ready);
endinterface

interface wmg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/wmg_cfg_regs.sv]
// ============================================================================
// Windowed watchdog motor guard register file
// Holds the window limits, fault budget, activity period and motor duties.
// ============================================================================
module wmg_cfg_regs
    import wmg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [CFG_INDEX_BITS-1:0] wr_index,
    input  logic [CFG_DATA_BITS-1:0]  wr_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_WINDOW_LOW:        cfg_next.window_low        = wr_data;
                REG_WINDOW_HIGH:       cfg_next.window_high       = wr_data;
                REG_FAULT_LIMIT:       cfg_next.fault_limit       = wr_data[6:0];
                REG_ACTIVITY_PERIOD:   cfg_next.activity_period   = wr_data[11:0];
                REG_LEFT_NORMAL_DUTY:  cfg_next.left_normal_duty  = wr_data[7:0];
                REG_LEFT_TURBO_DUTY:   cfg_next.left_turbo_duty   = wr_data[7:0];
                REG_RIGHT_NORMAL_DUTY: cfg_next.right_normal_duty = wr_data[7:0];
                REG_RIGHT_TURBO_DUTY:  cfg_next.right_turbo_duty  = wr_data[7:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_low        <= WINDOW_LOW_RST;
            cfg_reg.window_high       <= WINDOW_HIGH_RST;
            cfg_reg.fault_limit       <= FAULT_LIMIT_RST;
            cfg_reg.activity_period   <= ACTIVITY_PERIOD_RST;
            cfg_reg.left_normal_duty  <= NORMAL_DUTY_RST;
            cfg_reg.left_turbo_duty   <= TURBO_DUTY_RST;
            cfg_reg.right_normal_duty <= NORMAL_DUTY_RST;
            cfg_reg.right_turbo_duty  <= TURBO_DUTY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/wmg_guard_core.sv]
// ============================================================================
// Windowed watchdog motor guard core
// Guard state and the single-pass update that one item makes to it.
// ============================================================================
module wmg_guard_core
    import wmg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic                           watch_reg,    watch_next;
    logic [WINDOW_COUNTER_BITS-1:0] window_reg,   window_next;
    logic [7:0]                     fault_reg,    fault_next;
    sys_state_t                     state_reg,    state_next;
    logic [11:0]                    activity_reg, activity_next;
    logic                           emitter_reg,  emitter_next;
    logic [7:0]                     duty_reg  [4];
    logic [7:0]                     duty_next [4];

    logic [WINDOW_COUNTER_BITS-1:0] window_inc;
    logic [11:0]                    activity_inc;
    logic                           over_budget;
    logic                           late;
    logic                           early;
    logic                           ok;
    logic                           pulse;
    logic [7:0]                     fwd_duty;
    logic [7:0]                     turbo_duty;
    logic [7:0]                     run_duty;
    logic                           forward;

    assign window_inc   = window_reg + 1'b1;
    assign activity_inc = activity_reg + 1'b1;
    assign over_budget  = fault_reg > {1'b0, cfg.fault_limit};
    assign late  = CMP_BITS'(window_inc) > CMP_BITS'(cfg.window_high);
    assign early = CMP_BITS'(window_reg) < CMP_BITS'(cfg.window_low);

    assign fwd_duty   = item.motor_select ? cfg.right_normal_duty : cfg.left_normal_duty;
    assign turbo_duty = item.motor_select ? cfg.right_turbo_duty  : cfg.left_turbo_duty;
    assign run_duty   = (item.motor_command >= CMD_FORWARD_TURBO) ? turbo_duty : fwd_duty;
    assign forward    = (item.motor_command == CMD_FORWARD) ||
                        (item.motor_command == CMD_FORWARD_TURBO);

    always_comb
    begin
        watch_next    = watch_reg;
        window_next   = window_reg;
        fault_next    = fault_reg;
        state_next    = state_reg;
        activity_next = activity_reg;
        emitter_next  = emitter_reg;
        for (int i = 0; i < 4; i++)
        begin
            duty_next[i] = duty_reg[i];
        end
        ok    = 1'b1;
        pulse = 1'b0;

        case (op_t'(item.operation))
            OP_TICK:
            begin
                if (watch_reg)
                begin
                    window_next = window_inc;
                    if (late)
                    begin
                        if (over_budget)
                        begin
                            // Trip: counter keeps running so later faults trip again.
                            state_next   = ST_INACTIVE;
                            emitter_next = 1'b0;
                            for (int i = 0; i < 4; i++)
                            begin
                                duty_next[i] = BRAKE_DUTY;
                            end
                        end
                        else
                        begin
                            fault_next  = fault_reg + 1'b1;
                            window_next = '0;
                        end
                    end
                end
                if (activity_inc >= cfg.activity_period)
                begin
                    activity_next = '0;
                    pulse         = 1'b1;
                end
                else
                begin
                    activity_next = activity_inc;
                end
            end
            OP_KICK:
            begin
                if (watch_reg)
                begin
                    if (early)
                    begin
                        if (over_budget)
                        begin
                            state_next   = ST_INACTIVE;
                            emitter_next = 1'b0;
                            for (int i = 0; i < 4; i++)
                            begin
                                duty_next[i] = BRAKE_DUTY;
                            end
                        end
                        else
                        begin
                            fault_next  = fault_reg + 1'b1;
                            window_next = '0;
                        end
                    end
                    else
                    begin
                        if (fault_reg != '0)
                        begin
                            fault_next = fault_reg - 1'b1;
                        end
                        window_next = '0;
                    end
                end
            end
            OP_START:
            begin
                if (item.with_watchdog)
                begin
                    watch_next = 1'b1;
                end
                window_next  = '0;
                fault_next   = '0;
                state_next   = ST_ACTIVE;
                emitter_next = 1'b1;
            end
            OP_RESET:
            begin
                watch_next   = 1'b0;
                window_next  = '0;
                fault_next   = '0;
                state_next   = ST_WAITING;
                emitter_next = 1'b0;
            end
            OP_LOW_BATT:
            begin
                state_next   = ST_LOW_BATT;
                emitter_next = 1'b0;
                for (int i = 0; i < 4; i++)
                begin
                    duty_next[i] = BRAKE_DUTY;
                end
            end
            OP_MOTOR_CMD:
            begin
                if (item.motor_command > CMD_BACKWARD_TURBO)
                begin
                    ok = 1'b0;
                end
                else if (item.motor_command == CMD_STOP)
                begin
                    if (item.motor_select)
                    begin
                        duty_next[2] = BRAKE_DUTY;
                        duty_next[3] = BRAKE_DUTY;
                    end
                    else
                    begin
                        duty_next[0] = BRAKE_DUTY;
                        duty_next[1] = BRAKE_DUTY;
                    end
                end
                else if (item.motor_select)
                begin
                    // The right bridge is wired with its channels swapped.
                    duty_next[2] = forward ? 8'd0 : run_duty;
                    duty_next[3] = forward ? run_duty : 8'd0;
                end
                else
                begin
                    duty_next[0] = forward ? run_duty : 8'd0;
                    duty_next[1] = forward ? 8'd0 : run_duty;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            watch_reg    <= 1'b0;
            window_reg   <= '0;
            fault_reg    <= '0;
            state_reg    <= ST_WAITING;
            activity_reg <= '0;
            emitter_reg  <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                duty_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            watch_reg    <= watch_next;
            window_reg   <= window_next;
            fault_reg    <= fault_next;
            state_reg    <= state_next;
            activity_reg <= activity_next;
            emitter_reg  <= emitter_next;
            for (int i = 0; i < 4; i++)
            begin
                duty_reg[i] <= duty_next[i];
            end
        end
    end

    always_comb
    begin
        result.system_state   = state_code(state_next);
        result.command_ok     = ok;
        result.activity_pulse = pulse;
        result.emitter_enable = emitter_next;
        result.left_duty_a    = duty_next[0];
        result.left_duty_b    = duty_next[1];
        result.right_duty_a   = duty_next[2];
        result.right_duty_b   = duty_next[3];
    end

endmodule

[hdl/windowed_watchdog_motor_guard_unit.sv]
// ============================================================================
// Windowed watchdog motor guard unit
// An accepted beat goes through the input register, then the result register.
// One beat per cycle unless the result side stalls; one-pass state update.
// Reset clears the guard state, zeroes the motor duties and loads the
// register defaults; no clearing pass is needed after reset.
// ============================================================================
module windowed_watchdog_motor_guard_unit
    import wmg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    wmg_item_if.sink            item,
    wmg_result_if.source        result,
    wmg_cfg_if.sink             cfg
);

    // The datapath has two stages. An accepted item beat lands in the input
    // register. When the result register is free, or is being drained in the
    // same cycle, the guard core applies the item to its state and the result
    // is captured in the result register. Both registers move together, so a
    // new beat is taken every cycle unless the result side stalls.

    cfg_t    cfg_q;
    item_t   stage_item_reg;
    logic    stage_valid_reg;
    result_t out_result_reg;
    logic    out_valid_reg;
    result_t core_result;
    logic    advance;
    logic    take_item;

    // The user must send register writes only while the block is idle; the block
    // does not enforce it. Writes are taken at once.
    assign cfg.ready = 1'b1;

    wmg_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    // The staged item retires into the result register when that register is
    // empty or its current beat leaves this cycle.
    assign advance    = stage_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !stage_valid_reg || advance;
    assign take_item  = item.valid && item.ready;

    wmg_guard_core u_guard_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (stage_item_reg),
        .cfg    (cfg_q),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (take_item)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            stage_item_reg.operation     <= item.operation;
            stage_item_reg.with_watchdog <= item.with_watchdog;
            stage_item_reg.motor_select  <= item.motor_select;
            stage_item_reg.motor_command <= item.motor_command;
        end
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.system_state   = out_result_reg.system_state;
    assign result.command_ok     = out_result_reg.command_ok;
    assign result.activity_pulse = out_result_reg.activity_pulse;
    assign result.emitter_enable = out_result_reg.emitter_enable;
    assign result.left_duty_a    = out_result_reg.left_duty_a;
    assign result.left_duty_b    = out_result_reg.left_duty_b;
    assign result.right_duty_a   = out_result_reg.right_duty_a;
    assign result.right_duty_b   = out_result_reg.right_duty_b;

endmodule

[test/windowed_watchdog_motor_guard_unit_test.sv]
// ============================================================================
// Windowed watchdog motor guard unit testbench
// Drives operation beats into the guard, predicts every result beat from an
// in-bench model of the watchdog, fault budget and motor duties, and checks
// the results field by field under random idling on both channels.
// ============================================================================
module windowed_watchdog_motor_guard_unit_test;
    import wmg_pkg::*;

    // Operation and command codes that the package leaves unnamed.
    localparam logic [2:0] OP_SPARE_6  = 3'd6;
    localparam logic [2:0] OP_SPARE_7  = 3'd7;
    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    // A directed row either carries its result typed in, or leaves it to the
    // predictor.
    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;

    localparam int CLK_PERIOD     = 8;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int IDLE_PERCENT   = 38;

    typedef struct packed {
        item_t   stim;
        bit      typed;
        result_t want;
    } dir_row_t;

    // Directed opening, run with the register defaults. Duties are listed as
    // left A, left B, right A, right B. The right motor has its channels
    // swapped, so forward drives channel B there.
    localparam dir_row_t DIRECTED [25] = '{
        // A tick straight after reset: everything still at its reset value.
        '{'{OP_TICK, 1'b0, 1'b0, CMD_STOP}, TYPED,
          '{CODE_WAITING, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00}},
        // The two unused operation codes change nothing and are refused.
        '{'{OP_SPARE_6, 1'b1, 1'b1, CMD_SPARE_7}, TYPED,
          '{CODE_WAITING, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00}},
        '{'{OP_SPARE_7, 1'b1, 1'b1, CMD_SPARE_7}, TYPED,
          '{CODE_WAITING, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00}},
        // Every running motor command on both motors.
        '{'{OP_MOTOR_CMD, 1'b0, 1'b0, CMD_FORWARD}, TYPED,
          '{CODE_WAITING, 1'b1, 1'b0, 1'b0, 8'h35, 8'h00, 8'h00, 8'h00}},
        '{'{OP_MOTOR_CMD, 1'b0, 1'b1, CMD_FORWARD}, TYPED,
          '{CODE_WAITING, 1'b1, 1'b0, 1'b0, 8'h35, 8'h00, 8'h00, 8'h35}},
        '{'{OP_MOTOR_CMD, 1'b0, 1'b0, CMD_BACKWARD_TURBO}, TYPED,
          '{CODE_WAITING, 1'b1, 1'b0, 1'b0, 8'h00, 8'h70, 8'h00, 8'h35}},
        '{'{OP_MOTOR_CMD, 1'b0, 1'b1, CMD_FORWARD_TURBO}, TYPED,
          '{CODE_WAITING, 1'b1, 1'b0, 1'b0, 8'h00, 8'h70, 8'h00, 8'h70}},
        '{'{OP_MOTOR_CMD, 1'b0, 1'b1, CMD_BACKWARD}, TYPED,
          '{CODE_WAITING, 1'b1, 1'b0, 1'b0, 8'h00, 8'h70, 8'h35, 8'h00}},
        '{'{OP_MOTOR_CMD, 1'b0, 1'b0, CMD_FORWARD_TURBO}, TYPED,
          '{CODE_WAITING, 1'b1, 1'b0, 1'b0, 8'h70, 8'h00, 8'h35, 8'h00}},
        '{'{OP_MOTOR_CMD, 1'b0, 1'b0, CMD_BACKWARD}, TYPED,
          '{CODE_WAITING, 1'b1, 1'b0, 1'b0, 8'h00, 8'h35, 8'h35, 8'h00}},
        '{'{OP_MOTOR_CMD, 1'b0, 1'b1, CMD_BACKWARD_TURBO}, TYPED,
          '{CODE_WAITING, 1'b1, 1'b0, 1'b0, 8'h00, 8'h35, 8'h70, 8'h00}},
        // Invalid motor commands are refused, duties kept; a stop brakes left.
        '{'{OP_MOTOR_CMD, 1'b0, 1'b0, CMD_SPARE_5}, TYPED,
          '{CODE_WAITING, 1'b0, 1'b0, 1'b0, 8'h00, 8'h35, 8'h70, 8'h00}},
        '{'{OP_MOTOR_CMD, 1'b0, 1'b1, CMD_SPARE_6}, TYPED,
          '{CODE_WAITING, 1'b0, 1'b0, 1'b0, 8'h00, 8'h35, 8'h70, 8'h00}},
        '{'{OP_MOTOR_CMD, 1'b1, 1'b1, CMD_SPARE_7}, TYPED,
          '{CODE_WAITING, 1'b0, 1'b0, 1'b0, 8'h00, 8'h35, 8'h70, 8'h00}},
        '{'{OP_MOTOR_CMD, 1'b0, 1'b0, CMD_STOP}, TYPED,
          '{CODE_WAITING, 1'b1, 1'b0, 1'b0, 8'hFF, 8'hFF, 8'h70, 8'h00}},
        // A kick with the watchdog off, then a start without the watchdog.
        '{'{OP_KICK, 1'b0, 1'b0, CMD_STOP}, PREDICTED, '0},
        '{'{OP_START, 1'b0, 1'b0, CMD_STOP}, PREDICTED, '0},
        // Low battery brakes both motors; a reset keeps the duties.
        '{'{OP_LOW_BATT, 1'b0, 1'b0, CMD_STOP}, TYPED,
          '{CODE_LOW_BATT, 1'b1, 1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF}},
        '{'{OP_RESET, 1'b0, 1'b0, CMD_STOP}, TYPED,
          '{CODE_WAITING, 1'b1, 1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF}},
        // Watchdog on, an early kick, a tick, then a start without the
        // watchdog, which must leave it running, so the next kick is early.
        '{'{OP_START, 1'b1, 1'b0, CMD_STOP}, PREDICTED, '0},
        '{'{OP_KICK, 1'b0, 1'b0, CMD_STOP}, PREDICTED, '0},
        '{'{OP_TICK, 1'b1, 1'b1, CMD_SPARE_7}, PREDICTED, '0},
        '{'{OP_START, 1'b0, 1'b1, CMD_SPARE_7}, PREDICTED, '0},
        '{'{OP_KICK, 1'b1, 1'b1, CMD_SPARE_7}, PREDICTED, '0},
        '{'{OP_MOTOR_CMD, 1'b1, 1'b1, CMD_STOP}, PREDICTED, '0}
    };

    logic clk;
    logic rst_n;

    wmg_item_if   item_ch ();
    wmg_result_if result_ch ();
    wmg_cfg_if    cfg_ch ();

    windowed_watchdog_motor_guard_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Predicted guard state and the register copy it works with.
    cfg_t        regs = '{WINDOW_LOW_RST, WINDOW_HIGH_RST, FAULT_LIMIT_RST,
                          ACTIVITY_PERIOD_RST, NORMAL_DUTY_RST, TURBO_DUTY_RST,
                          NORMAL_DUTY_RST, TURBO_DUTY_RST};
    logic        wd_on    = 1'b0;
    logic [15:0] win_cnt  = '0;
    logic [7:0]  faults   = '0;
    logic [1:0]  sys_code = CODE_WAITING;
    logic [11:0] act_cnt  = '0;
    logic        emit_on  = 1'b0;
    logic [7:0]  duty [4] = '{default: 8'h00};

    result_t guard_outcomes [$];
    int      mismatches = 0;
    int      items_sent = 0;
    bit      no_gaps    = 1'b0;

    // A fault either trips the guard, once the budget is already exceeded,
    // or is booked and restarts the window. Tripping leaves the counter as it
    // is, so every further fault brakes the motors again.
    function automatic void charge_fault();
        if (faults > {1'b0, regs.fault_limit}) begin
            sys_code = CODE_INACTIVE;
            emit_on  = 1'b0;
            foreach (duty[i]) duty[i] = BRAKE_DUTY;
        end else begin
            faults  = faults + 8'd1;
            win_cnt = '0;
        end
    endfunction

    // Advances the predicted guard by one operation and returns the result
    // beat that it must produce.
    function automatic result_t guard_step(input item_t it);
        result_t    res;
        logic       ok;
        logic       pulse;
        logic [7:0] level;
        int         base;
        int         fwd_ch;
        int         back_ch;
        ok    = 1'b1;
        pulse = 1'b0;
        case (it.operation)
            OP_TICK: begin
                if (wd_on) begin
                    win_cnt = win_cnt + 16'd1;
                    if (win_cnt > regs.window_high) charge_fault();
                end
                // The activity counter runs on every tick, watchdog or not.
                act_cnt = act_cnt + 12'd1;
                if (act_cnt >= regs.activity_period) begin
                    act_cnt = '0;
                    pulse   = 1'b1;
                end
            end
            OP_KICK: begin
                if (wd_on) begin
                    if (win_cnt < regs.window_low) begin
                        charge_fault();
                    end else begin
                        if (faults != 8'd0) faults = faults - 8'd1;
                        win_cnt = '0;
                    end
                end
            end
            OP_START: begin
                if (it.with_watchdog) wd_on = 1'b1;
                win_cnt  = '0;
                faults   = '0;
                sys_code = CODE_ACTIVE;
                emit_on  = 1'b1;
            end
            OP_RESET: begin
                wd_on    = 1'b0;
                win_cnt  = '0;
                faults   = '0;
                sys_code = CODE_WAITING;
                emit_on  = 1'b0;
            end
            OP_LOW_BATT: begin
                sys_code = CODE_LOW_BATT;
                emit_on  = 1'b0;
                foreach (duty[i]) duty[i] = BRAKE_DUTY;
            end
            OP_MOTOR_CMD: begin
                base = it.motor_select ? 2 : 0;
                if (it.motor_command > CMD_BACKWARD_TURBO) begin
                    ok = 1'b0;
                end else if (it.motor_command == CMD_STOP) begin
                    duty[base]     = BRAKE_DUTY;
                    duty[base + 1] = BRAKE_DUTY;
                end else begin
                    if (it.motor_command >= CMD_FORWARD_TURBO)
                        level = it.motor_select ? regs.right_turbo_duty
                                                : regs.left_turbo_duty;
                    else
                        level = it.motor_select ? regs.right_normal_duty
                                                : regs.left_normal_duty;
                    // The right bridge is wired the other way round.
                    fwd_ch  = it.motor_select ? base + 1 : base;
                    back_ch = it.motor_select ? base : base + 1;
                    if (it.motor_command == CMD_FORWARD ||
                        it.motor_command == CMD_FORWARD_TURBO) begin
                        duty[fwd_ch]  = level;
                        duty[back_ch] = 8'h00;
                    end else begin
                        duty[back_ch] = level;
                        duty[fwd_ch]  = 8'h00;
                    end
                end
            end
            default: ok = 1'b0;
        endcase
        res.system_state   = sys_code;
        res.command_ok     = ok;
        res.activity_pulse = pulse;
        res.emitter_enable = emit_on;
        res.left_duty_a    = duty[0];
        res.left_duty_b    = duty[1];
        res.right_duty_a   = duty[2];
        res.right_duty_b   = duty[3];
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic item_t rand_item(input logic [2:0] op);
        item_t it;
        it.operation     = op;
        it.with_watchdog = 1'($urandom_range(0, 1));
        it.motor_select  = 1'($urandom_range(0, 1));
        it.motor_command = 3'($urandom_range(0, 7));
        return it;
    endfunction

    // Presents one operation beat, idling first at random unless the calm
    // stretch is running. The beat's outcome is queued at the accepting edge;
    // a typed row supplies its own outcome while the predictor still steps.
    task automatic send_item(input item_t it, input bit typed = 1'b0,
                             input result_t want = '0);
        result_t predicted;
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PERCENT) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.operation     <= it.operation;
        item_ch.with_watchdog <= it.with_watchdog;
        item_ch.motor_select  <= it.motor_select;
        item_ch.motor_command <= it.motor_command;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        predicted = guard_step(it);
        guard_outcomes.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Drops valid and holds off until every queued outcome has been seen.
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (guard_outcomes.size() != 0) @(posedge clk);
    endtask

    // Writes all eight registers back to back. Unused upper data bits carry
    // random junk, which the narrow registers must ignore.
    task automatic load_settings(input cfg_t s);
        reg_index_t  idx;
        logic [15:0] word;
        for (int i = 0; i < 8; i++) begin
            idx  = reg_index_t'(i);
            word = 16'($urandom);
            case (idx)
                REG_WINDOW_LOW:        word       = s.window_low;
                REG_WINDOW_HIGH:       word       = s.window_high;
                REG_FAULT_LIMIT:       word[6:0]  = s.fault_limit;
                REG_ACTIVITY_PERIOD:   word[11:0] = s.activity_period;
                REG_LEFT_NORMAL_DUTY:  word[7:0]  = s.left_normal_duty;
                REG_LEFT_TURBO_DUTY:   word[7:0]  = s.left_turbo_duty;
                REG_RIGHT_NORMAL_DUTY: word[7:0]  = s.right_normal_duty;
                REG_RIGHT_TURBO_DUTY:  word[7:0]  = s.right_turbo_duty;
                default:               word       = 16'($urandom);
            endcase
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx;
            cfg_ch.data  <= word;
            @(posedge clk);
            while (!cfg_ch.ready) @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        regs = s;
    endtask

    // Random traffic. Most of it is watchdog service: a burst of ticks, up to
    // 22 or two past a smaller window top, with the odd motor command mixed in,
    // closed by a kick, so that early, timely and late kicks all occur and the
    // fault budget fills and trips. Starts re-arm the guard after a trip; the
    // rest is motor commands and fully random beats, unused codes included.
    task automatic feed_random(input int count);
        int stop_at;
        int span;
        int roll;
        int burst;
        item_t it;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            span = (regs.window_high > 16'd20) ? 22 : int'(regs.window_high) + 2;
            roll = int'($urandom_range(0, 99));
            if (roll < 55) begin
                burst = int'($urandom_range(0, span));
                repeat (burst) begin
                    if ($urandom_range(0, 99) < 15)
                        send_item(rand_item(OP_MOTOR_CMD));
                    send_item(rand_item(OP_TICK));
                end
                send_item(rand_item(OP_KICK));
            end else if (roll < 65) begin
                it = rand_item(OP_START);
                it.with_watchdog = ($urandom_range(0, 9) != 0);
                send_item(it);
            end else if (roll < 85) begin
                send_item(rand_item(OP_MOTOR_CMD));
            end else begin
                send_item(rand_item(3'($urandom_range(0, 7))));
            end
            // Now and then the sender holds back until the block has caught up.
            if ($urandom_range(0, 49) == 0) wait_drained();
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Result side: checks each accepted beat against the oldest outcome and
    // stalls at random, except in the calm stretch.
    initial begin
        result_t want;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (result_ch.valid && result_ch.ready) begin
                if (guard_outcomes.size() == 0) begin
                    $error("result beat arrived with no outcome pending");
                    mismatches++;
                end else begin
                    want = guard_outcomes.pop_front();
                    check_field("system_state", 8'(want.system_state),
                                8'(result_ch.system_state));
                    check_field("command_ok", 8'(want.command_ok),
                                8'(result_ch.command_ok));
                    check_field("activity_pulse", 8'(want.activity_pulse),
                                8'(result_ch.activity_pulse));
                    check_field("emitter_enable", 8'(want.emitter_enable),
                                8'(result_ch.emitter_enable));
                    check_field("left_duty_a", want.left_duty_a, result_ch.left_duty_a);
                    check_field("left_duty_b", want.left_duty_b, result_ch.left_duty_b);
                    check_field("right_duty_a", want.right_duty_a, result_ch.right_duty_a);
                    check_field("right_duty_b", want.right_duty_b, result_ch.right_duty_b);
                end
            end
            result_ch.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PERCENT);
            @(posedge clk);
        end
    end

    // Main sequence: reset, the directed table, then phases of random traffic
    // under different register settings. Registers are only rewritten once
    // every outcome of the previous phase has been seen.
    initial begin
        cfg_t s;
        rst_n                 <= 1'b0;
        item_ch.valid         <= 1'b0;
        item_ch.operation     <= OP_TICK;
        item_ch.with_watchdog <= 1'b0;
        item_ch.motor_select  <= 1'b0;
        item_ch.motor_command <= CMD_STOP;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= REG_WINDOW_LOW;
        cfg_ch.data           <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i]) send_item(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);
        wait_drained();

        // A narrow window and a small budget, run without any idling so that
        // beats flow back to back on both sides.
        no_gaps = 1'b1;
        s = '{16'd3, 16'd9, 7'd2, 12'd7, 8'h35, 8'h70, 8'h40, 8'h90};
        load_settings(s);
        feed_random(200);
        wait_drained();
        no_gaps = 1'b0;

        // All registers at zero: every watched tick is late, the second fault
        // trips, kicks are never early and the activity pulse fires on every
        // tick.
        s = '0;
        load_settings(s);
        feed_random(100);
        wait_drained();

        // All registers at their top values: every kick is early and the
        // window is never overrun within reach.
        s = '{16'hFFFF, 16'hFFFF, 7'h7F, 12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        load_settings(s);
        feed_random(150);
        wait_drained();

        // Random small windows, budgets, periods and duties.
        repeat (4) begin
            s.window_low        = 16'($urandom_range(0, 6));
            s.window_high       = s.window_low + 16'($urandom_range(0, 8));
            s.fault_limit       = 7'($urandom_range(0, 3));
            s.activity_period   = 12'($urandom_range(1, 10));
            s.left_normal_duty  = 8'($urandom);
            s.left_turbo_duty   = 8'($urandom);
            s.right_normal_duty = 8'($urandom);
            s.right_turbo_duty  = 8'($urandom);
            load_settings(s);
            feed_random(100);
            wait_drained();
        end

        // Idle on so that a stray extra result beat would be caught.
        repeat (4) @(posedge clk);
        if (mismatches == 0 && guard_outcomes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
hdl/wmg_pkg.sv
hdl/wmg_chan_if.sv
hdl/wmg_cfg_regs.sv
hdl/wmg_guard_core.sv
hdl/windowed_watchdog_motor_guard_unit.sv
test/windowed_watchdog_motor_guard_unit_test.sv
